FILE: hdl/rbbp_pkg.sv
// shared types and constants of the refcounted block buffer pool
`default_nettype none
package rbbp_pkg;

  localparam int unsigned REF_BITS = 10;
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_FREE    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_MACRO = 2'd1,
    STAT_NO_DESC  = 2'd2
  } status_t;

  typedef struct packed {
    logic rd;
    logic pop;
    logic push;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

endpackage
`default_nettype wire

FILE: hdl/refcounted_block_buffer_pool_unit.sv
// top level of the refcounted block buffer pool: sequencer, metadata rams, result register
//
// Hands out block descriptors and macro buffers for read requests and takes
// them back on frees. One word is worked on at a time: a request does one ram
// read of tag, refcount and both stack tops, then the update, and a free adds
// a further state because the refcount read can only be issued once the
// owner of the descriptor has come back from its ram. The result sits in an
// output register, so the next word is taken while a result waits. When a
// pool is empty the request is answered with a retry status and nothing
// changes. No clearing pass is needed after reset.
`default_nettype none
module refcounted_block_buffer_pool_unit
  import rbbp_pkg::*;
#(
  parameter int unsigned DESCRIPTOR_COUNT  = 512,
  parameter int unsigned MACRO_COUNT       = 32,
  parameter int unsigned MACRO_OFFSET_BITS = 15,
  parameter int unsigned POSITION_BITS     = 40,
  localparam int unsigned DW     = $clog2(DESCRIPTOR_COUNT),
  localparam int unsigned MW     = $clog2(MACRO_COUNT),
  localparam int unsigned IN_FW  = POSITION_BITS + DW,
  localparam int unsigned IN_DW  = ((IN_FW + 7) / 8) * 8,
  localparam int unsigned OUT_FW = DW + MW + MACRO_OFFSET_BITS + POSITION_BITS + 2,
  localparam int unsigned OUT_DW = ((OUT_FW + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // position, freed_descriptor, zero pad
  input  wire logic              in_tuser,   // operation
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [OUT_DW-1:0] out_tdata,  // descriptor, macro_index, block_offset,
                                             // fetch_needed, fetch_address,
                                             // macro_released, zero pad
  output logic      [1:0]        out_tuser   // status
);

  localparam int unsigned OFFB = MACRO_OFFSET_BITS;
  localparam int unsigned PB   = POSITION_BITS;
  localparam int unsigned TW   = PB - OFFB;
  localparam logic [DW:0] DESC_N = (DW + 1)'(DESCRIPTOR_COUNT);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_FREE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic          op_r;
  logic [PB-1:0] pos_r;
  logic [DW-1:0] id_r;

  logic          cur_valid_r, cur_valid_nxt;
  logic [MW-1:0] cur_r, cur_nxt;
  logic [MACRO_COUNT-1:0] rc_valid_r, rc_valid_nxt;

  logic              out_valid_r;
  logic [1:0]        out_stat_r;
  logic [OUT_FW-1:0] out_data_r;

  logic accept, out_free, finish, free_go, ignore;
  logic commit_req, commit_free;

  logic [TW-1:0]       tag_q, tag;
  logic [MW-1:0]       owner_q;
  logic [REF_BITS-1:0] rc_q;
  logic [DW-1:0]       d_top;
  logic [MW-1:0]       m_top;
  stk_cmd_t            d_cmd, m_cmd;
  stk_stat_t           d_stat, m_stat;

  logic                rc_we, rc_rd;
  logic [MW-1:0]       rc_waddr, rc_raddr;
  logic [REF_BITS-1:0] rc_wdata;

  logic [OFFB-1:0]     offset;
  logic [PB-1:0]       madr;
  logic [REF_BITS-1:0] rc_cur, rc_base, rc_inc, rc_f, rc_dec;
  logic                miss, reuse, no_macro, no_desc, req_ok, rel;
  logic [MW-1:0]       m_new;

  logic [1:0]        res_stat;
  logic [OUT_FW-1:0] res_data;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign ignore  = ({1'b0, id_r} >= DESC_N) || d_stat.full;
  assign free_go = (state_r == S_LOOK) && (op_r == OP_FREE) && !ignore;
  assign finish  = out_free && (((state_r == S_LOOK) && !free_go) || (state_r == S_FREE));

  // request path
  assign tag    = pos_r[PB-1:OFFB];
  assign offset = pos_r[OFFB-1:0];
  assign madr   = {tag, {OFFB{1'b0}}};

  assign rc_cur   = rc_valid_r[cur_r] ? rc_q : '0;
  assign miss     = !cur_valid_r || (tag_q != tag);
  assign reuse    = cur_valid_r && (rc_cur == '0);
  assign no_macro = miss && !reuse && m_stat.empty;
  assign no_desc  = d_stat.empty;
  assign req_ok   = !no_macro && !no_desc;
  assign m_new    = (miss && !reuse) ? m_top : cur_r;
  assign rc_base  = miss ? '0 : rc_cur;
  assign rc_inc   = (rc_base == REF_MAX) ? rc_base : rc_base + REF_BITS'(1);

  // free path
  assign rc_f   = rc_valid_r[owner_q] ? rc_q : '0;
  assign rc_dec = rc_f - REF_BITS'(1);
  assign rel    = (rc_f != '0) && (rc_dec == '0) && !(cur_valid_r && (cur_r == owner_q));

  assign commit_req  = finish && (state_r == S_LOOK) && (op_r == OP_REQUEST) && req_ok;
  assign commit_free = finish && (state_r == S_FREE);

  rbbp_ram #(
    .WIDTH (TW),
    .DEPTH (MACRO_COUNT)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (commit_req && miss),
    .wr_addr (m_new),
    .wr_data (tag),
    .rd_en   (accept),
    .rd_addr (cur_r),
    .rd_data (tag_q)
  );

  rbbp_ram #(
    .WIDTH (MW),
    .DEPTH (DESCRIPTOR_COUNT)
  ) u_owner_ram (
    .clk     (clk),
    .wr_en   (commit_req),
    .wr_addr (d_top),
    .wr_data (m_new),
    .rd_en   (accept),
    .rd_addr (in_tdata[PB+DW-1:PB]),
    .rd_data (owner_q)
  );

  assign rc_rd    = accept || free_go;
  assign rc_raddr = (state_r == S_LOOK) ? owner_q : cur_r;
  assign rc_we    = commit_req || (commit_free && (rc_f != '0));
  assign rc_waddr = commit_free ? owner_q : m_new;
  assign rc_wdata = commit_free ? rc_dec : rc_inc;

  rbbp_ram #(
    .WIDTH (REF_BITS),
    .DEPTH (MACRO_COUNT)
  ) u_rc_ram (
    .clk     (clk),
    .wr_en   (rc_we),
    .wr_addr (rc_waddr),
    .wr_data (rc_wdata),
    .rd_en   (rc_rd),
    .rd_addr (rc_raddr),
    .rd_data (rc_q)
  );

  assign d_cmd.rd   = accept;
  assign d_cmd.pop  = commit_req;
  assign d_cmd.push = commit_free;

  rbbp_stack #(
    .DEPTH (DESCRIPTOR_COUNT)
  ) u_desc_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (d_cmd),
    .push_data (id_r),
    .top_data  (d_top),
    .stat      (d_stat)
  );

  assign m_cmd.rd   = accept;
  assign m_cmd.pop  = commit_req && miss && !reuse;
  assign m_cmd.push = commit_free && rel && !m_stat.full;

  rbbp_stack #(
    .DEPTH (MACRO_COUNT)
  ) u_macro_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (m_cmd),
    .push_data (owner_q),
    .top_data  (m_top),
    .stat      (m_stat)
  );

  // result word
  always_comb begin
    res_stat = STAT_OK;
    res_data = '0;
    if (state_r == S_FREE) begin
      res_data = {rel, {PB{1'b0}}, 1'b0, {OFFB{1'b0}}, owner_q, {DW{1'b0}}};
    end else if (op_r == OP_REQUEST) begin
      if (no_macro) begin
        res_stat = STAT_NO_MACRO;
      end else if (no_desc) begin
        res_stat = STAT_NO_DESC;
      end else begin
        res_data = {1'b0, (miss ? madr : {PB{1'b0}}), miss, offset, m_new, d_top};
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    rc_valid_nxt  = rc_valid_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (free_go) begin
          state_nxt = S_FREE;
        end else if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      S_FREE: begin
        if (finish) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (commit_req && miss) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = m_new;
    end
    if (rc_we) begin
      rc_valid_nxt[rc_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_valid_r <= 1'b0;
      cur_r       <= '0;
      rc_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_r       <= cur_nxt;
      rc_valid_r  <= rc_valid_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_tuser;
      pos_r <= in_tdata[PB-1:0];
      id_r  <= in_tdata[PB+DW-1:PB];
    end
    if (finish) begin
      out_stat_r <= res_stat;
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = OUT_DW'(out_data_r);

endmodule
`default_nettype wire

FILE: hdl/rbbp_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none
module rbbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rbbp_stack.sv
// free-id stack in ram, preloaded contents tracked by a low-water mark
`default_nettype none
module rbbp_stack
  import rbbp_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire stk_cmd_t      cmd,
  input  wire logic [AW-1:0] push_data,
  output logic      [AW-1:0] top_data,
  output stk_stat_t          stat
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] low_r, low_nxt;
  logic [CW-1:0] count_dec;
  logic [AW-1:0] ram_q;

  assign count_dec = count_r - CW'(1);

  rbbp_ram #(
    .WIDTH (AW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (push_data),
    .rd_en   (cmd.rd),
    .rd_addr (count_dec[AW-1:0]),
    .rd_data (ram_q)
  );

  // entries below the low-water mark still hold their preload value
  always_comb begin
    if (count_r > low_r) begin
      top_data = ram_q;
    end else begin
      top_data = AW'(FULL - count_r);
    end
  end

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == FULL);

  always_comb begin
    count_nxt = count_r;
    low_nxt   = low_r;
    if (cmd.pop) begin
      count_nxt = count_dec;
      if (count_dec < low_r) begin
        low_nxt = count_dec;
      end
    end else if (cmd.push) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= FULL;
      low_r   <= FULL;
    end else begin
      count_r <= count_nxt;
      low_r   <= low_nxt;
    end
  end

endmodule
`default_nettype wire
